/* rtl/core/bds_pkg.sv */
// ----------------------------------------------------------------------------
// bds_pkg
// shared types and constants of the box filter downscaler
// ----------------------------------------------------------------------------
package bds_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned IMG_W_W    = 11;
  localparam int unsigned IMG_H_W    = 13;
  localparam int unsigned FACT_W     = 4;

  localparam logic [IMG_W_W-1:0] IMG_W_RST  = 11'd1024;
  localparam logic [IMG_H_W-1:0] IMG_H_RST  = 13'd1024;
  localparam logic [FACT_W-1:0]  FACT_RST   = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_SHRINK_FACTOR = 2'd2
  } cfg_reg_e;

  // column field of a queued operation, wide enough for the largest line
  localparam int unsigned COL_W  = 13;
  localparam int unsigned FIDX_W = 4;

  // position recompute divider: one lane per quotient
  localparam int unsigned DIV_W     = 13;
  localparam int unsigned DIV_LANES = 4;
  localparam int unsigned LANE_X    = 0;
  localparam int unsigned LANE_Y    = 1;
  localparam int unsigned LANE_W    = 2;
  localparam int unsigned LANE_H    = 3;

  // reciprocal of the block area, ceil(2^24 / (f*f)), exact for sums below 2^16
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_W     = 25;
  localparam logic [RECIP_W-1:0] RECIP_TBL [16] = '{
    25'd16777216, 25'd4194304, 25'd1864136, 25'd1048576,
    25'd671089,   25'd466034,  25'd342393,  25'd262144,
    25'd207127,   25'd167773,  25'd138655,  25'd116509,
    25'd99274,    25'd85599,   25'd74566,   25'd65536
  };

  typedef struct packed {
    logic [7:0] pix_red;
    logic [7:0] pix_green;
    logic [7:0] pix_blue;
  } pix_t;

  typedef struct packed {
    logic [7:0] avg_red;
    logic [7:0] avg_green;
    logic [7:0] avg_blue;
    logic       row_end;
    logic       frame_end;
  } out_t;

  // one accumulate operation handed from front to back
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic              first;
    logic              emit;
    logic              row_end;
    logic              frame_end;
    logic [FIDX_W-1:0] fidx;
    pix_t              pix;
  } op_t;

endpackage

/* rtl/core/bds_ram.sv */
// ----------------------------------------------------------------------------
// bds_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* rtl/core/bds_div.sv */
// ----------------------------------------------------------------------------
// bds_div
// four lane restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bds_div #(
  parameter int unsigned FW = 4
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               start_i,
  input  logic [bds_pkg::DIV_LANES-1:0][bds_pkg::DIV_W-1:0]  dvd_i,
  input  logic [FW-1:0]                                      dvs_i,
  output logic                                               busy_o,
  output logic                                               done_o,
  output logic [bds_pkg::DIV_LANES-1:0][bds_pkg::DIV_W-1:0]  quo_o,
  output logic [bds_pkg::DIV_LANES-1:0][FW-1:0]              rem_o
);

  localparam int unsigned CW = $clog2(bds_pkg::DIV_W);

  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [FW-1:0] dvs_q;
  logic [bds_pkg::DIV_LANES-1:0][bds_pkg::DIV_W-1:0] dq_q, dq_d;
  logic [bds_pkg::DIV_LANES-1:0][FW-1:0]             rem_q, rem_d;

  // one restoring step per lane
  always_comb begin
    logic [FW:0] part;
    logic        ge;
    dq_d  = dq_q;
    rem_d = rem_q;
    for (int l = 0; l < bds_pkg::DIV_LANES; l++) begin
      part     = {rem_q[l], dq_q[l][bds_pkg::DIV_W-1]};
      ge       = part >= {1'b0, dvs_q};
      rem_d[l] = ge ? FW'(part - {1'b0, dvs_q}) : FW'(part);
      dq_d[l]  = {dq_q[l][bds_pkg::DIV_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
        done_q <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(bds_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dvd_i;
      rem_q <= '0;
      dvs_q <= dvs_i;
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = dq_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/core/bds_front.sv */
// ----------------------------------------------------------------------------
// bds_front
// configuration, pixel position tracking and classification of each word
// ----------------------------------------------------------------------------
module bds_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_FACTOR = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bds_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bds_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  input  bds_pkg::pix_t                    in_data_i,
  output logic                             in_stall_o,
  input  logic                             hold_i,
  input  logic                             full_i,
  output logic                             push_o,
  output bds_pkg::op_t                     op_o
);

  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = XW + 1;
  localparam int unsigned FW  = $clog2(MAX_FACTOR + 1);
  localparam int unsigned CBW = $clog2(MAX_FACTOR);
  localparam int unsigned HW  = bds_pkg::IMG_H_W;
  localparam int unsigned HW1 = HW + 1;
  localparam int unsigned EW  = (WW > bds_pkg::IMG_W_W) ? WW : bds_pkg::IMG_W_W;
  localparam int unsigned EF  = (FW > bds_pkg::FACT_W) ? FW : bds_pkg::FACT_W;

  logic [bds_pkg::IMG_W_W-1:0] cfg_w_q;
  logic [bds_pkg::IMG_H_W-1:0] cfg_h_q;
  logic [bds_pkg::FACT_W-1:0]  cfg_f_q;
  logic                        rec_pend_q;

  logic [XW-1:0]  x_q, x_d, bc_q, bc_d;
  logic [HW-1:0]  y_q, y_d, br_q, br_d;
  logic [CBW-1:0] cib_q, cib_d, rib_q, rib_d, xr_q, xr_d, yr_q, yr_d;
  logic [WW-1:0]  out_w_q;
  logic [HW-1:0]  out_h_q;

  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [FW-1:0] eff_f;
  logic [EW-1:0] w_ext;
  logic [EF-1:0] f_ext;

  logic accept;
  logic cib_end, rib_end, xr_end, yr_end, x_last, y_last;
  logic in_crop, row_end;

  logic                                              div_busy, div_done;
  logic [bds_pkg::DIV_LANES-1:0][bds_pkg::DIV_W-1:0] div_dvd, div_quo;
  logic [bds_pkg::DIV_LANES-1:0][FW-1:0]             div_rem;

  // effective geometry, zero values clamped, oversize width and factor clamped
  always_comb begin
    w_ext = EW'(cfg_w_q);
    f_ext = EF'(cfg_f_q);
    if (w_ext == '0) begin
      eff_w = WW'(1);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(w_ext);
    end
    eff_h = (cfg_h_q == '0) ? HW'(1) : cfg_h_q;
    if (f_ext == '0) begin
      eff_f = FW'(1);
    end else if (f_ext > EF'(MAX_FACTOR)) begin
      eff_f = FW'(MAX_FACTOR);
    end else begin
      eff_f = FW'(f_ext);
    end
  end

  // block column, block row and output size, recomputed after config
  always_comb begin
    div_dvd         = '0;
    div_dvd[bds_pkg::LANE_X] = bds_pkg::DIV_W'(x_q);
    div_dvd[bds_pkg::LANE_Y] = bds_pkg::DIV_W'(y_q);
    div_dvd[bds_pkg::LANE_W] = bds_pkg::DIV_W'(eff_w);
    div_dvd[bds_pkg::LANE_H] = bds_pkg::DIV_W'(eff_h);
  end

  bds_div #(
    .FW (FW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rec_pend_q),
    .dvd_i   (div_dvd),
    .dvs_i   (eff_f),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  assign in_stall_o = rec_pend_q | div_busy | div_done | hold_i | full_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // classification
  always_comb begin
    cib_end = (FW'(cib_q) + FW'(1)) >= eff_f;
    rib_end = (FW'(rib_q) + FW'(1)) >= eff_f;
    xr_end  = (FW'(xr_q) + FW'(1)) >= eff_f;
    yr_end  = (FW'(yr_q) + FW'(1)) >= eff_f;
    x_last  = ({1'b0, x_q} + WW'(1)) >= eff_w;
    y_last  = ({1'b0, y_q} + HW1'(1)) >= {1'b0, eff_h};
    in_crop = ({1'b0, bc_q} < out_w_q) && (br_q < out_h_q);
    row_end = ({1'b0, bc_q} + WW'(1)) == out_w_q;

    op_o.col       = bds_pkg::COL_W'(bc_q);
    op_o.first     = (cib_q == '0) && (rib_q == '0);
    op_o.emit      = cib_end & rib_end;
    op_o.row_end   = row_end;
    op_o.frame_end = row_end && (({1'b0, br_q} + HW1'(1)) == {1'b0, out_h_q});
    op_o.fidx      = bds_pkg::FIDX_W'(eff_f - FW'(1));
    op_o.pix       = in_data_i;
  end

  assign push_o = accept & in_crop;

  // position advance
  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    cib_d = cib_q;
    rib_d = rib_q;
    bc_d  = bc_q;
    xr_d  = xr_q;
    br_d  = br_q;
    yr_d  = yr_q;
    if (x_last) begin
      x_d   = '0;
      cib_d = '0;
      bc_d  = '0;
      xr_d  = '0;
      rib_d = rib_end ? '0 : rib_q + CBW'(1);
      if (y_last) begin
        y_d   = '0;
        rib_d = '0;
        br_d  = '0;
        yr_d  = '0;
      end else begin
        y_d = y_q + HW'(1);
        if (yr_end) begin
          yr_d = '0;
          br_d = br_q + HW'(1);
        end else begin
          yr_d = yr_q + CBW'(1);
        end
      end
    end else begin
      x_d   = x_q + XW'(1);
      cib_d = cib_end ? '0 : cib_q + CBW'(1);
      if (xr_end) begin
        xr_d = '0;
        bc_d = bc_q + XW'(1);
      end else begin
        xr_d = xr_q + CBW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q    <= bds_pkg::IMG_W_RST;
      cfg_h_q    <= bds_pkg::IMG_H_RST;
      cfg_f_q    <= bds_pkg::FACT_RST;
      rec_pend_q <= 1'b1;
      x_q        <= '0;
      y_q        <= '0;
      cib_q      <= '0;
      rib_q      <= '0;
      bc_q       <= '0;
      xr_q       <= '0;
      br_q       <= '0;
      yr_q       <= '0;
      out_w_q    <= '0;
      out_h_q    <= '0;
    end else begin
      rec_pend_q <= cfg_we_i;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bds_pkg::REG_IMAGE_WIDTH:   cfg_w_q <= cfg_data_i[bds_pkg::IMG_W_W-1:0];
          bds_pkg::REG_IMAGE_HEIGHT:  cfg_h_q <= cfg_data_i[bds_pkg::IMG_H_W-1:0];
          bds_pkg::REG_SHRINK_FACTOR: cfg_f_q <= cfg_data_i[bds_pkg::FACT_W-1:0];
          default: ;
        endcase
      end
      if (div_done) begin
        bc_q    <= XW'(div_quo[bds_pkg::LANE_X]);
        xr_q    <= CBW'(div_rem[bds_pkg::LANE_X]);
        br_q    <= HW'(div_quo[bds_pkg::LANE_Y]);
        yr_q    <= CBW'(div_rem[bds_pkg::LANE_Y]);
        out_w_q <= WW'(div_quo[bds_pkg::LANE_W]);
        out_h_q <= HW'(div_quo[bds_pkg::LANE_H]);
      end else if (accept) begin
        x_q   <= x_d;
        y_q   <= y_d;
        cib_q <= cib_d;
        rib_q <= rib_d;
        bc_q  <= bc_d;
        xr_q  <= xr_d;
        br_q  <= br_d;
        yr_q  <= yr_d;
      end
    end
  end

endmodule

/* rtl/core/bds_queue.sv */
// ----------------------------------------------------------------------------
// bds_queue
// small register fifo of accumulate operations between front and back
// ----------------------------------------------------------------------------
module bds_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  bds_pkg::op_t op_i,
  output logic         full_o,
  input  logic         pop_i,
  output bds_pkg::op_t op_o,
  output logic         valid_o
);

  localparam int unsigned PTW  = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  bds_pkg::op_t   mem [DEPTH];
  logic [PTW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CNTW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign op_o    = mem[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTW'(DEPTH - 1)) ? '0 : wr_ptr_q + PTW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTW'(DEPTH - 1)) ? '0 : rd_ptr_q + PTW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CNTW'(1);
        2'b01:   cnt_q <= cnt_q - CNTW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= op_i;
    end
  end

endmodule

/* rtl/core/bds_back.sv */
// ----------------------------------------------------------------------------
// bds_back
// column sum read-modify-write, mean by reciprocal multiply, output register
// ----------------------------------------------------------------------------
module bds_back #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_FACTOR = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bds_pkg::op_t  op_i,
  input  logic          op_valid_i,
  output logic          pop_o,
  output logic          clearing_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bds_pkg::out_t out_data_o
);

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned SW = 8 + 2 * $clog2(MAX_FACTOR);
  localparam int unsigned MW = 3 * SW;
  localparam int unsigned PW = SW + bds_pkg::RECIP_W;

  logic              clr_busy_q;
  logic [XW-1:0]     clr_addr_q;
  logic              adv;

  logic              s1_vld_q;
  bds_pkg::op_t      s1_op_q;
  logic [XW-1:0]     s1_col;
  logic [MW-1:0]     rd_data;
  logic [2:0][SW-1:0] rd_sum, base_sum, new_sum, pix_ext;

  logic              wr_vld_q;
  logic [XW-1:0]     wr_col_q;
  logic [2:0][SW-1:0] wr_sum_q;

  logic               s2_vld_q, s2_re_q, s2_fe_q;
  logic [2:0][SW-1:0] s2_sum_q;
  logic [bds_pkg::RECIP_W-1:0] s2_recip_q;

  logic               s3_vld_q, s3_re_q, s3_fe_q;
  logic [2:0][PW-1:0] s3_prod_q;

  logic               out_vld_q;
  bds_pkg::out_t      out_q;

  logic               ram_we;
  logic [XW-1:0]      ram_waddr;
  logic [MW-1:0]      ram_wdata;

  assign adv        = ~out_vld_q | ~out_stall_i;
  assign pop_o      = adv & ~clr_busy_q & op_valid_i;
  assign clearing_o = clr_busy_q;
  assign s1_col     = s1_op_q.col[XW-1:0];

  // accumulate, with bypass of the write made while this word was read
  always_comb begin
    rd_sum     = rd_data;
    pix_ext[0] = SW'(s1_op_q.pix.pix_red);
    pix_ext[1] = SW'(s1_op_q.pix.pix_green);
    pix_ext[2] = SW'(s1_op_q.pix.pix_blue);
    base_sum   = (wr_vld_q && wr_col_q == s1_col) ? wr_sum_q : rd_sum;
    for (int c = 0; c < 3; c++) begin
      new_sum[c] = s1_op_q.first ? pix_ext[c] : base_sum[c] + pix_ext[c];
    end
  end

  always_comb begin
    ram_we    = clr_busy_q | (adv & s1_vld_q);
    ram_waddr = clr_busy_q ? clr_addr_q : s1_col;
    ram_wdata = clr_busy_q ? '0 : MW'(new_sum);
  end

  bds_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_WIDTH)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (pop_o),
    .raddr_i (op_i.col[XW-1:0]),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      s1_vld_q   <= 1'b0;
      wr_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      s3_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + XW'(1);
        if (clr_addr_q == XW'(MAX_WIDTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (adv) begin
        s1_vld_q  <= pop_o;
        wr_vld_q  <= s1_vld_q;
        s2_vld_q  <= s1_vld_q & s1_op_q.emit;
        s3_vld_q  <= s2_vld_q;
        out_vld_q <= s3_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q    <= op_i;
      wr_col_q   <= s1_col;
      wr_sum_q   <= new_sum;
      s2_sum_q   <= new_sum;
      s2_recip_q <= bds_pkg::RECIP_TBL[s1_op_q.fidx];
      s2_re_q    <= s1_op_q.row_end;
      s2_fe_q    <= s1_op_q.frame_end;
      for (int c = 0; c < 3; c++) begin
        s3_prod_q[c] <= PW'(s2_sum_q[c]) * PW'(s2_recip_q);
      end
      s3_re_q             <= s2_re_q;
      s3_fe_q             <= s2_fe_q;
      out_q.avg_red       <= s3_prod_q[0][bds_pkg::RECIP_SHIFT +: 8];
      out_q.avg_green     <= s3_prod_q[1][bds_pkg::RECIP_SHIFT +: 8];
      out_q.avg_blue      <= s3_prod_q[2][bds_pkg::RECIP_SHIFT +: 8];
      out_q.row_end       <= s3_re_q;
      out_q.frame_end     <= s3_fe_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/core/box_downscale_rgb.sv */
// ----------------------------------------------------------------------------
// box_downscale_rgb
// streaming rgb image downscaler by box filter over integer sized squares
// ----------------------------------------------------------------------------
// Pixels of a frame enter in raster order, one word per clock when nothing
// stalls; each output word is the per channel truncated mean of one square of
// side shrink_factor, passes the queue and the read, sum, product and output
// registers after the bottom-right pixel of its square, and is tagged with row
// end and frame end. The sustained rate is one pixel per clock while not
// stalled, set by the read-modify-write of the column sum memory (registered
// read, then write, with a bypass between neighbors). After reset the input
// stalls while MAX_WIDTH (1024 by default) sum entries are cleared, one entry
// a cycle. After every register write the input stalls while block column,
// block row and output size are recomputed by a four lane bit serial divider.
// Columns and rows beyond a whole number of squares are cropped; they only move
// the position. Registers may be written only while no result is outstanding.
// ----------------------------------------------------------------------------
module box_downscale_rgb #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned MAX_FACTOR  = 8,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // register writes
  input  logic                           cfg_we_i,
  input  logic [bds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // pixel input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bds_pkg::pix_t                  in_data_i,
  // averaged output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bds_pkg::out_t                  out_data_o
);

  // front to queue
  logic         push;
  bds_pkg::op_t push_op;
  logic         q_full;

  // queue to back
  logic         pop;
  bds_pkg::op_t head_op;
  logic         head_vld;

  // back holds the input off while the sum memory is being cleared
  logic         clearing;

  // front end: registers, position counters, crop and emit decisions
  bds_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .hold_i     (clearing),
    .full_i     (q_full),
    .push_o     (push),
    .op_o       (push_op)
  );

  // decoupling queue, only pixels inside the cropped area are queued
  bds_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (pop),
    .op_o    (head_op),
    .valid_o (head_vld)
  );

  // back end: column sums, mean and output register
  bds_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (head_op),
    .op_valid_i  (head_vld),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
